// ===== rtl/core/fsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared types, constants and helper functions for the font strip glyph
// segmenter: register codes, settings bundle, event record and clamping.
// ----------------------------------------------------------------------------
package fsg_pkg;

    // Field widths
    localparam int PIX_W    = 16;
    localparam int COL_W    = 13;
    localparam int LEFT_W   = 12;
    localparam int ROW_W    = 8;
    localparam int NUM_W    = 7;
    localparam int HEIGHT_W = 9;

    // Glyph table size: at most GLYPH_SLOTS-1 glyphs are reported
    localparam int GLYPH_SLOTS = 95;

    // Space width divisor and its scaled reciprocal
    localparam int SPACE_DIV   = 95;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + SPACE_DIV - 1) / SPACE_DIV;
    localparam int PROD_W      = 30;

    // Register reset values
    localparam logic [COL_W-1:0]    RST_WIDTH  = 13'd950;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 9'd16;
    localparam logic [PIX_W-1:0]    RST_KEY    = 16'd0;

    // Register index codes
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KEY_COLOR    = 2'd2
    } t_cfg_idx;

    // Settings as used by the datapath (already clamped)
    typedef struct packed {
        logic [LEFT_W-1:0] width_m1;
        logic [ROW_W-1:0]  height_m1;
        logic [PIX_W-1:0]  key;
        logic [NUM_W-1:0]  space;
    } t_cfg;

    // Everything one pixel can cause: an optional glyph, an optional summary
    typedef struct packed {
        logic              has_glyph;
        logic [NUM_W-1:0]  glyph_number;
        logic [LEFT_W-1:0] left_column;
        logic [COL_W-1:0]  right_bound;
        logic [ROW_W-1:0]  bottom_row;
        logic              has_sum;
        logic [NUM_W-1:0]  glyph_total;
        logic [NUM_W-1:0]  space_width;
    } t_event;

    // Width clamped to 1..4096, minus one
    function automatic logic [LEFT_W-1:0] width_m1_of(input logic [COL_W-1:0] w);
        logic [COL_W-1:0] d;
        begin
            d = w - 13'd1;
            if (w == '0) begin
                width_m1_of = '0;
            end else if (w[COL_W-1] && (w[COL_W-2:0] != '0)) begin
                width_m1_of = '1;
            end else begin
                width_m1_of = d[LEFT_W-1:0];
            end
        end
    endfunction

    // Height clamped to 1..256, minus one
    function automatic logic [ROW_W-1:0] height_m1_of(input logic [HEIGHT_W-1:0] h);
        logic [HEIGHT_W-1:0] d;
        begin
            d = h - 9'd1;
            if (h == '0) begin
                height_m1_of = '0;
            end else if (h[HEIGHT_W-1] && (h[HEIGHT_W-2:0] != '0)) begin
                height_m1_of = '1;
            end else begin
                height_m1_of = d[ROW_W-1:0];
            end
        end
    endfunction

    // Clamped width / 95 - 1, by reciprocal multiply (exact for 13-bit widths)
    function automatic logic [NUM_W-1:0] space_of(input logic [COL_W-1:0] w);
        logic [COL_W-1:0]  wc;
        logic [PROD_W-1:0] prod;
        logic [NUM_W-1:0]  q;
        begin
            wc   = {1'b0, width_m1_of(w)} + 13'd1;
            prod = PROD_W'(wc) * PROD_W'(RECIP);
            q    = prod[RECIP_SHIFT +: NUM_W];
            space_of = q - 7'd1;
        end
    endfunction

endpackage

// ===== rtl/core/fsg_seg.sv =====
// ----------------------------------------------------------------------------
// fsg_seg
// Column scanner: row/column counters, clear-column tracking and run
// detection. Each processed pixel yields at most one event record.
// ----------------------------------------------------------------------------
module fsg_seg #(
    parameter int GLYPH_SLOTS = fsg_pkg::GLYPH_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [fsg_pkg::PIX_W-1:0]     i_pixel,
    input  fsg_pkg::t_cfg                 i_cfg,
    output logic                          o_evt_valid,
    output fsg_pkg::t_event               o_evt
);
    import fsg_pkg::*;

    logic [ROW_W-1:0]  r_row,       n_row;
    logic [COL_W-1:0]  r_col,       n_col;
    logic              r_col_clear, n_col_clear;
    logic              r_in_run,    n_in_run;
    logic [LEFT_W-1:0] r_run_start, n_run_start;
    logic [NUM_W-1:0]  r_found,     n_found;

    logic              clr_now, col_done, last_col;
    logic              new_run, in_run_mid, glyph_a, glyph_b, room, has_glyph, has_sum;
    logic [LEFT_W-1:0] start_mid;
    logic [NUM_W-1:0]  found_mid;

    // Per-pixel decisions
    always_comb begin
        clr_now    = r_col_clear && (i_pixel == i_cfg.key);
        col_done   = !(r_row < i_cfg.height_m1);
        last_col   = r_col >= {1'b0, i_cfg.width_m1};
        // run closed by a clear column
        glyph_a    = col_done && clr_now && r_in_run;
        new_run    = col_done && !clr_now && !r_in_run;
        in_run_mid = col_done ? !clr_now : r_in_run;
        start_mid  = new_run ? r_col[LEFT_W-1:0] : r_run_start;
        // run closed by the right edge
        glyph_b    = col_done && last_col && in_run_mid;
        room       = r_found < NUM_W'(GLYPH_SLOTS - 1);
        has_glyph  = (glyph_a || glyph_b) && room;
        has_sum    = col_done && last_col;
        found_mid  = r_found + {{(NUM_W-1){1'b0}}, has_glyph};

        o_evt_valid        = has_glyph || has_sum;
        o_evt.has_glyph    = has_glyph;
        o_evt.glyph_number = r_found;
        o_evt.left_column  = start_mid;
        o_evt.right_bound  = glyph_b ? (r_col + 13'd2) : (r_col + 13'd1);
        o_evt.bottom_row   = i_cfg.height_m1;
        o_evt.has_sum      = has_sum;
        o_evt.glyph_total  = found_mid + 7'd1;
        o_evt.space_width  = i_cfg.space;
    end

    // Next state
    always_comb begin
        n_row       = col_done ? '0 : (r_row + 8'd1);
        n_col_clear = col_done ? 1'b1 : clr_now;
        n_col       = col_done ? (last_col ? '0 : (r_col + 13'd1)) : r_col;
        n_in_run    = has_sum ? 1'b0 : in_run_mid;
        n_run_start = has_sum ? '0 : start_mid;
        n_found     = has_sum ? '0 : found_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_col_clear <= 1'b1;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
            r_found     <= '0;
        end else if (i_step) begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_col_clear <= n_col_clear;
            r_in_run    <= n_in_run;
            r_run_start <= n_run_start;
            r_found     <= n_found;
        end
    end

endmodule

// ===== rtl/core/fsg_outq.sv =====
// ----------------------------------------------------------------------------
// fsg_outq
// Two-entry event queue feeding the result channel. An event holding both a
// glyph and a summary is sent as two results, glyph first.
// ----------------------------------------------------------------------------
module fsg_outq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  fsg_pkg::t_event                    i_evt,
    output logic                               o_full,
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output logic                               o_kind,
    output logic [fsg_pkg::NUM_W-1:0]          o_glyph_number,
    output logic [fsg_pkg::LEFT_W-1:0]         o_left_column,
    output logic [fsg_pkg::COL_W-1:0]          o_right_bound,
    output logic [fsg_pkg::ROW_W-1:0]          o_bottom_row,
    output logic [fsg_pkg::NUM_W-1:0]          o_glyph_total,
    output logic signed [fsg_pkg::NUM_W-1:0]   o_space_width,
    output logic                               o_last
);
    import fsg_pkg::*;

    t_event     r_q [2];
    logic       r_wp, r_rp, r_half;
    logic [1:0] r_cnt;

    t_event     head;
    logic       show_glyph, take, pop;

    // Head decode
    always_comb begin
        head        = r_q[r_rp];
        o_res_valid = r_cnt != 2'd0;
        o_full      = r_cnt == 2'd2;
        show_glyph  = head.has_glyph && !r_half;
        take        = o_res_valid && !i_res_stall;
        pop         = take && (!show_glyph || !head.has_sum);

        o_kind         = !show_glyph;
        o_last         = !show_glyph;
        o_glyph_number = show_glyph ? head.glyph_number : '0;
        o_left_column  = show_glyph ? head.left_column  : '0;
        o_right_bound  = show_glyph ? head.right_bound  : '0;
        o_bottom_row   = show_glyph ? head.bottom_row   : '0;
        o_glyph_total  = show_glyph ? '0 : head.glyph_total;
        o_space_width  = show_glyph ? '0 : $signed(head.space_width);
    end

    // Event storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_evt;
        end
    end

    // Pointers, fill count, glyph-sent flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
            r_half <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp   <= !r_rp;
                r_half <= 1'b0;
            end else if (take) begin
                r_half <= 1'b1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/font_strip_glyph_segmenter.sv =====
// ----------------------------------------------------------------------------
// font_strip_glyph_segmenter
// Splits a column-major font strip into glyph rectangles by key-color
// columns and closes each image with a summary result.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------
//  pixel     | in        | i_pixel_valid / o_pixel_stall| i_pixel
//  result    | out       | o_res_valid / i_res_stall    | o_kind .. o_last
//  config    | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One pixel per cycle while the queue has room: a pixel is held in the input
//  register, then the scanner updates its counters and files any results into a
//  two-entry queue. The last pixel of a run-closing final column gives two
//  results, glyph first. The pixel input stalls only while the queue is full.
//  Reset (synchronous, low) empties the queue and restores the settings.
// ----------------------------------------------------------------------------
module font_strip_glyph_segmenter #(
    parameter int GLYPH_SLOTS = fsg_pkg::GLYPH_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pixel_valid,
    output logic                               o_pixel_stall,
    input  logic [fsg_pkg::PIX_W-1:0]          i_pixel,
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output logic                               o_kind,
    output logic [fsg_pkg::NUM_W-1:0]          o_glyph_number,
    output logic [fsg_pkg::LEFT_W-1:0]         o_left_column,
    output logic [fsg_pkg::COL_W-1:0]          o_right_bound,
    output logic [fsg_pkg::ROW_W-1:0]          o_bottom_row,
    output logic [fsg_pkg::NUM_W-1:0]          o_glyph_total,
    output logic signed [fsg_pkg::NUM_W-1:0]   o_space_width,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [fsg_pkg::PIX_W-1:0]          i_cfg_data
);
    import fsg_pkg::*;

    t_cfg             r_cfg;
    logic             r_pix_valid;
    logic [PIX_W-1:0] r_pix;
    logic             q_full, step, load, evt_valid;
    t_event           evt;

    // Configuration writes, stored clamped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_m1  <= width_m1_of(RST_WIDTH);
            r_cfg.height_m1 <= height_m1_of(RST_HEIGHT);
            r_cfg.key       <= RST_KEY;
            r_cfg.space     <= space_of(RST_WIDTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_cfg.width_m1 <= width_m1_of(i_cfg_data[COL_W-1:0]);
                    r_cfg.space    <= space_of(i_cfg_data[COL_W-1:0]);
                end
                CFG_IMAGE_HEIGHT: begin
                    r_cfg.height_m1 <= height_m1_of(i_cfg_data[HEIGHT_W-1:0]);
                end
                CFG_KEY_COLOR: begin
                    r_cfg.key <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_comb begin
        step          = r_pix_valid && !q_full;
        o_pixel_stall = r_pix_valid && q_full;
        load          = i_pixel_valid && !o_pixel_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (load) begin
            r_pix_valid <= 1'b1;
        end else if (step) begin
            r_pix_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pix <= i_pixel;
        end
    end

    fsg_seg #(
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pixel     (r_pix),
        .i_cfg       (r_cfg),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    fsg_outq u_outq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (step && evt_valid),
        .i_evt          (evt),
        .o_full         (q_full),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_kind         (o_kind),
        .o_glyph_number (o_glyph_number),
        .o_left_column  (o_left_column),
        .o_right_bound  (o_right_bound),
        .o_bottom_row   (o_bottom_row),
        .o_glyph_total  (o_glyph_total),
        .o_space_width  (o_space_width),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/core/fsg_chk.sv =====
// ----------------------------------------------------------------------------
// fsg_chk
// Port-level checks for the font strip glyph segmenter, bound to the top.
// ----------------------------------------------------------------------------
module fsg_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_res_valid,
    input logic                               i_res_stall,
    input logic                               o_kind,
    input logic [fsg_pkg::LEFT_W-1:0]         o_left_column,
    input logic [fsg_pkg::COL_W-1:0]          o_right_bound,
    input logic [fsg_pkg::NUM_W-1:0]          o_glyph_total,
    input logic                               o_last
);
    import fsg_pkg::*;

    // Stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=>
            o_res_valid && $stable(o_kind) && $stable(o_right_bound)
            && $stable(o_glyph_total))
        else $error("stalled result changed");

    // Only summaries close an image
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_last == o_kind))
        else $error("last flag does not match kind");

    // A glyph spans at least one column
    a_glyph_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_kind |-> (o_right_bound > {1'b0, o_left_column}))
        else $error("glyph right bound not past left column");

    // Queue is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

endmodule

bind font_strip_glyph_segmenter fsg_chk u_fsg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_res_valid   (o_res_valid),
    .i_res_stall   (i_res_stall),
    .o_kind        (o_kind),
    .o_left_column (o_left_column),
    .o_right_bound (o_right_bound),
    .o_glyph_total (o_glyph_total),
    .o_last        (o_last)
);
